// ===== hdl/csc_pkg.sv =====
`timescale 1ns / 1ps

package csc_pkg;

  localparam int COORD_WIDTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int RADIUS_WIDTH = 15;
  localparam int RR_WIDTH = 2 * RADIUS_WIDTH;

  typedef struct packed {
    logic endpoint_hit;
    logic in_range;
  } seg_class_t;

endpackage

// ===== hdl/circle_segment_collision_unit.sv =====
`timescale 1ns / 1ps
// An accepted transaction goes through the front pipeline, queue and back pipeline to out_valid.
// Throughput is one transaction per cycle while out_stall is low; multipliers are pipelined.
// Up to QUEUE_DEPTH classified transactions wait between front and back while the output stalls.
// Synchronous active-high reset empties the pipelines and the queue.

module circle_segment_collision_unit #(
  parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = csc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     centre_x,
  input  logic signed [COORD_WIDTH-1:0]     centre_y,
  input  logic [csc_pkg::RADIUS_WIDTH-1:0]  radius,
  input  logic signed [COORD_WIDTH-1:0]     start_x,
  input  logic signed [COORD_WIDTH-1:0]     start_y,
  input  logic signed [COORD_WIDTH-1:0]     end_x,
  input  logic signed [COORD_WIDTH-1:0]     end_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit
);

  localparam int SQW = 2 * COORD_WIDTH + 2;
  localparam int QW = $bits(csc_pkg::seg_class_t) + 3 * SQW + csc_pkg::RR_WIDTH;

  logic q_full, q_empty, push, pop;
  csc_pkg::seg_class_t f_cls, q_cls;
  logic [SQW-1:0] f_f2, f_len2, f_dot, q_f2, q_len2, q_dot;
  logic [csc_pkg::RR_WIDTH-1:0] f_rr, q_rr;
  logic [QW-1:0] q_wr, q_rd;

  csc_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .centre_x (centre_x),
    .centre_y (centre_y),
    .radius   (radius),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .q_full   (q_full),
    .push     (push),
    .cls      (f_cls),
    .f2       (f_f2),
    .rr       (f_rr),
    .len2     (f_len2),
    .dot      (f_dot)
  );

  assign q_wr = {f_cls, f_f2, f_rr, f_len2, f_dot};
  assign {q_cls, q_f2, q_rr, q_len2, q_dot} = q_rd;

  csc_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (q_wr),
    .pop     (pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  csc_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .pop       (pop),
    .cls       (q_cls),
    .f2        (q_f2),
    .rr        (q_rr),
    .len2      (q_len2),
    .dot       (q_dot),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit)
  );

endmodule

// ===== hdl/csc_front.sv =====
`timescale 1ns / 1ps

module csc_front #(
  parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_WIDTH-1:0]         centre_x,
  input  logic signed [COORD_WIDTH-1:0]         centre_y,
  input  logic [csc_pkg::RADIUS_WIDTH-1:0]      radius,
  input  logic signed [COORD_WIDTH-1:0]         start_x,
  input  logic signed [COORD_WIDTH-1:0]         start_y,
  input  logic signed [COORD_WIDTH-1:0]         end_x,
  input  logic signed [COORD_WIDTH-1:0]         end_y,
  input  logic                                  q_full,
  output logic                                  push,
  output csc_pkg::seg_class_t                   cls,
  output logic [2*COORD_WIDTH+1:0]              f2,
  output logic [csc_pkg::RR_WIDTH-1:0]          rr,
  output logic [2*COORD_WIDTH+1:0]              len2,
  output logic [2*COORD_WIDTH+1:0]              dot
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int SQW = 2 * COORD_WIDTH + 2;
  localparam int DOTW = SQW + 1;
  localparam int EW = (SQW > csc_pkg::RR_WIDTH) ? SQW : csc_pkg::RR_WIDTH;

  logic en;
  logic v1, v2, v3;

  logic signed [DW-1:0] fx, fy, gx, gy, abx, aby;
  logic [csc_pkg::RADIUS_WIDTH-1:0] r1;

  logic [SQW-1:0] fx2, fy2, gx2, gy2, ax2, ay2;
  logic signed [SQW-1:0] pfx, pfy;
  logic [csc_pkg::RR_WIDTH-1:0] rr2;

  logic [SQW-1:0] f2_sum, g2_sum, len2_sum;
  logic signed [DOTW-1:0] dot_sum;
  logic [EW-1:0] f2_ext, g2_ext, rr_ext;
  csc_pkg::seg_class_t cls_next;

  assign en = !(v3 && q_full);
  assign in_stall = !en;
  assign push = v3 && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx  <= {centre_x[COORD_WIDTH-1], centre_x} - {start_x[COORD_WIDTH-1], start_x};
      fy  <= {centre_y[COORD_WIDTH-1], centre_y} - {start_y[COORD_WIDTH-1], start_y};
      gx  <= {centre_x[COORD_WIDTH-1], centre_x} - {end_x[COORD_WIDTH-1], end_x};
      gy  <= {centre_y[COORD_WIDTH-1], centre_y} - {end_y[COORD_WIDTH-1], end_y};
      abx <= {end_x[COORD_WIDTH-1], end_x} - {start_x[COORD_WIDTH-1], start_x};
      aby <= {end_y[COORD_WIDTH-1], end_y} - {start_y[COORD_WIDTH-1], start_y};
      r1  <= radius;

      fx2 <= fx * fx;
      fy2 <= fy * fy;
      gx2 <= gx * gx;
      gy2 <= gy * gy;
      ax2 <= abx * abx;
      ay2 <= aby * aby;
      pfx <= fx * abx;
      pfy <= fy * aby;
      rr2 <= r1 * r1;

      cls  <= cls_next;
      f2   <= f2_sum;
      rr   <= rr2;
      len2 <= len2_sum;
      dot  <= dot_sum[SQW-1:0];
    end
  end

  always_comb begin
    f2_sum   = fx2 + fy2;
    g2_sum   = gx2 + gy2;
    len2_sum = ax2 + ay2;
    dot_sum  = DOTW'(pfx) + DOTW'(pfy);
    f2_ext   = EW'(f2_sum);
    g2_ext   = EW'(g2_sum);
    rr_ext   = EW'(rr2);
    cls_next.endpoint_hit = (f2_ext < rr_ext) || (g2_ext < rr_ext);
    cls_next.in_range = (len2_sum != '0) && !dot_sum[DOTW-1] &&
                        (dot_sum <= $signed({1'b0, len2_sum}));
  end

endmodule

// ===== hdl/csc_queue.sv =====
`timescale 1ns / 1ps

module csc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = csc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count, count_next;

  assign full = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("Queue written while full.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("Queue read while empty.");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("Queue count exceeds its depth.");

endmodule

// ===== hdl/csc_back.sv =====
`timescale 1ns / 1ps

module csc_back #(
  parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  output logic                          pop,
  input  csc_pkg::seg_class_t           cls,
  input  logic [2*COORD_WIDTH+1:0]      f2,
  input  logic [csc_pkg::RR_WIDTH-1:0]  rr,
  input  logic [2*COORD_WIDTH+1:0]      len2,
  input  logic [2*COORD_WIDTH+1:0]      dot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit
);

  localparam int SQW = 2 * COORD_WIDTH + 2;
  localparam int EW = (SQW > csc_pkg::RR_WIDTH) ? SQW : csc_pkg::RR_WIDTH;
  localparam int H = (EW + 1) / 2;
  localparam int OW = 2 * H;
  localparam int PW = 4 * H;

  logic en;
  logic v1, v2, v3, v4;
  csc_pkg::seg_class_t cls1, cls2, cls3, cls4;

  logic [OW-1:0] excess, len2_1, dot_1;

  logic [2*H-1:0] a_hh, a_hl, a_lh, a_ll;
  logic [2*H-1:0] d_hh, d_hl, d_ll;

  logic [2*H-1:0] a_hh3, a_ll3, d_hh3, d_ll3;
  logic [2*H:0] a_mid, d_mid;

  logic [PW-1:0] a_full, d_full;

  assign en = !out_valid || !out_stall;
  assign pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= !q_empty;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls1   <= cls;
      excess <= OW'(EW'(f2) - EW'(rr));
      len2_1 <= OW'(len2);
      dot_1  <= OW'(dot);

      cls2 <= cls1;
      a_hh <= excess[OW-1:H] * len2_1[OW-1:H];
      a_hl <= excess[OW-1:H] * len2_1[H-1:0];
      a_lh <= excess[H-1:0] * len2_1[OW-1:H];
      a_ll <= excess[H-1:0] * len2_1[H-1:0];
      d_hh <= dot_1[OW-1:H] * dot_1[OW-1:H];
      d_hl <= dot_1[OW-1:H] * dot_1[H-1:0];
      d_ll <= dot_1[H-1:0] * dot_1[H-1:0];

      cls3  <= cls2;
      a_hh3 <= a_hh;
      a_ll3 <= a_ll;
      d_hh3 <= d_hh;
      d_ll3 <= d_ll;
      a_mid <= (2*H+1)'(a_hl) + (2*H+1)'(a_lh);
      d_mid <= {d_hl, 1'b0};

      cls4   <= cls3;
      a_full <= {a_hh3, a_ll3} + (PW'(a_mid) << H);
      d_full <= {d_hh3, d_ll3} + (PW'(d_mid) << H);

      hit <= cls4.endpoint_hit || (cls4.in_range && (a_full < d_full));
    end
  end

endmodule

// ===== tb/circle_segment_collision_unit_tb.sv =====
`timescale 1ns / 1ps

module circle_segment_collision_unit_tb;

  localparam int CW = csc_pkg::COORD_WIDTH_DEFAULT;
  localparam int RW = csc_pkg::RADIUS_WIDTH;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef struct {
    logic signed [CW-1:0] centre_x;
    logic signed [CW-1:0] centre_y;
    logic [RW-1:0]        radius;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
  } seg_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] centre_x = '0;
  logic signed [CW-1:0] centre_y = '0;
  logic [RW-1:0]        radius = '0;
  logic signed [CW-1:0] start_x = '0;
  logic signed [CW-1:0] start_y = '0;
  logic signed [CW-1:0] end_x = '0;
  logic signed [CW-1:0] end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;

  seg_pair_t pending_pairs[$];
  bit        expected_hits[$];

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;
  bit hold_started = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int failures = 0;
  int pairs_sent = 0;
  int hits_seen = 0;
  int misses_seen = 0;
  int input_stall_cycles = 0;

  circle_segment_collision_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .centre_x(centre_x),
    .centre_y(centre_y),
    .radius(radius),
    .start_x(start_x),
    .start_y(start_y),
    .end_x(end_x),
    .end_y(end_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit)
  );

  always #6 clk = ~clk;

  // Exact integer form of the collision test; every intermediate fits in 128 bits.
  function automatic bit predict_hit(input seg_pair_t p);
    logic signed [127:0] cx, cy, rd, sx, sy, ex, ey;
    logic signed [127:0] fx, fy, gx, gy, abx, aby, f2, g2, rr, len2, dot;
    cx = p.centre_x;
    cy = p.centre_y;
    rd = p.radius;
    sx = p.start_x;
    sy = p.start_y;
    ex = p.end_x;
    ey = p.end_y;
    fx = cx - sx;
    fy = cy - sy;
    gx = cx - ex;
    gy = cy - ey;
    abx = ex - sx;
    aby = ey - sy;
    f2 = fx * fx + fy * fy;
    g2 = gx * gx + gy * gy;
    rr = rd * rd;
    if (f2 < rr || g2 < rr) begin
      return 1'b1;
    end
    len2 = abx * abx + aby * aby;
    dot = fx * abx + fy * aby;
    return (len2 != 0) && (dot >= 0) && (dot <= len2) && ((f2 - rr) * len2 < dot * dot);
  endfunction

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic add_pair(input int cx, input int cy, input int r, input int sx,
                          input int sy, input int ex, input int ey);
    seg_pair_t p;
    p.centre_x = cx[CW-1:0];
    p.centre_y = cy[CW-1:0];
    p.radius = r[RW-1:0];
    p.start_x = sx[CW-1:0];
    p.start_y = sy[CW-1:0];
    p.end_x = ex[CW-1:0];
    p.end_y = ey[CW-1:0];
    pending_pairs.push_back(p);
  endtask

  task automatic add_random_pair();
    int kind, cx, cy, r, reach, d, a, b, sgn;
    kind = $urandom_range(9);
    cx = span(-20000, 20000);
    cy = span(-20000, 20000);
    r = ($urandom_range(7) == 0) ? $urandom_range(32767) : $urandom_range(2000);
    reach = 2 * r + 64;
    sgn = $urandom_range(1) ? 1 : -1;
    case (kind)
      0, 1: begin
        add_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      2, 3, 4: begin
        add_pair(cx, cy, r, cx + span(-reach, reach), cy + span(-reach, reach),
                 cx + span(-reach, reach), cy + span(-reach, reach));
      end
      5: begin
        a = cx + span(-reach, reach);
        b = cy + span(-reach, reach);
        add_pair(cx, cy, r, a, b, a, b);
      end
      6: begin
        // Segment parallel to an axis at distance r-1, r or r+1 from the centre.
        d = sgn * (r + span(-1, 1));
        a = span(r + 1, reach);
        b = span(r + 1, reach);
        if ($urandom_range(1)) begin
          add_pair(cx, cy, r, cx - a, cy + d, cx + b, cy + d);
        end else begin
          add_pair(cx, cy, r, cx + d, cy + a, cx + d, cy - b);
        end
      end
      7: begin
        add_pair(cx, cy, 0, cx + span(-4, 4), cy + span(-4, 4),
                 cx + span(-reach, reach), cy + span(-reach, reach));
      end
      8: begin
        // One endpoint lies on the circle boundary.
        a = span(-reach, reach);
        b = span(-reach, reach);
        if ($urandom_range(1)) begin
          add_pair(cx, cy, r, cx + sgn * r, cy, cx + a, cy + b);
        end else begin
          add_pair(cx, cy, r, cx + a, cy + b, cx, cy + sgn * r);
        end
      end
      default: begin
        // The centre projects onto an endpoint or just beside it, on either side.
        a = span(-reach, reach);
        d = span(-2, 2);
        add_pair(cx, cy, r, cx + d, cy + a, cx + d + sgn * span(1, reach), cy + a);
      end
    endcase
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_valid || expected_hits.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    @(negedge clk);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) add_random_pair();
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        seg_pair_t acc;
        acc.centre_x = centre_x;
        acc.centre_y = centre_y;
        acc.radius = radius;
        acc.start_x = start_x;
        acc.start_y = start_y;
        acc.end_x = end_x;
        acc.end_y = end_y;
        expected_hits.push_back(predict_hit(acc));
        pairs_sent <= pairs_sent + 1;
      end
      if (in_valid && in_stall) begin
        input_stall_cycles <= input_stall_cycles + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_pairs.size() != 0 && int'($urandom_range(99)) >= idle_pct) begin
          seg_pair_t nxt;
          nxt = pending_pairs.pop_front();
          centre_x <= nxt.centre_x;
          centre_y <= nxt.centre_y;
          radius <= nxt.radius;
          start_x <= nxt.start_x;
          start_y <= nxt.start_y;
          end_x <= nxt.end_x;
          end_y <= nxt.end_y;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_started <= 1'b0;
    end else if (hold_request && !hold_started) begin
      hold_left <= LONG_HOLD_CYCLES;
      hold_started <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          failures <= failures + 1;
          if (failures < 10) begin
            $display("Unexpected result transaction: hit=%0b at cycle %0d", hit, cycle_count);
          end
        end else begin
          bit want;
          want = expected_hits.pop_front();
          if (hit !== want) begin
            failures <= failures + 1;
            if (failures < 10) begin
              $display("Mismatch on hit: expected %0b, actual %0b at cycle %0d",
                       want, hit, cycle_count);
            end
          end
          if (want) begin
            hits_seen <= hits_seen + 1;
          end else begin
            misses_seen <= misses_seen + 1;
          end
        end
      end
      out_stall <= (hold_left > 0) || (int'($urandom_range(99)) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    add_pair(0, 0, 16, -100, 16, 100, 16);
    add_pair(0, 0, 16, -100, 15, 100, 15);
    add_pair(0, 0, 16, 16, 0, 100, 0);
    add_pair(0, 0, 16, 15, 0, 100, 0);
    add_pair(0, 0, 0, 0, 0, 0, 0);
    add_pair(0, 0, 32767, 0, 0, 0, 0);
    add_pair(10000, 10000, 100, 5000, 5000, 5000, 5000);
    add_pair(0, 0, 32767, -32768, -32768, 32767, 32767);
    add_pair(-32768, -32768, 32767, -32768, -32768, -32768, -32768);
    add_pair(32767, 32767, 32767, -32768, -32768, -32768, 32767);
    add_pair(-32768, 32767, 0, -32768, 32767, 32767, -32768);
    add_pair(0, 0, 100, -50, 200, 50, 200);
    add_pair(0, 0, 100, 200, -50, 200, 50);
    add_pair(0, 0, 300, -400, 0, 400, 0);
    add_pair(0, 0, 300, 400, 0, 1000, 0);
    add_pair(0, 0, 300, -1000, 0, -400, 0);
    add_pair(0, 0, 300, 0, 400, 0, -400);
    add_pair(32767, -32768, 32767, 32767, -32768, -32768, 32767);
    add_pair(-1, -1, 1, -1, -1, -1, -1);
    add_pair(-32768, -32768, 32767, 32767, 32767, 32767, -32768);
    add_pair(21845, -21846, 32767, -21846, 21845, 21845, 21845);
    add_pair(0, 0, 300, 0, 300, 300, 300);
    wait_drained();

    run_phase(0, 0, 400);
    run_phase(81, 0, 380);
    run_phase(0, 81, 380);
    run_phase(25, 25, 400);

    @(negedge clk);
    hold_request = 1'b1;
    idle_pct = 0;
    stall_pct = 0;
    repeat (390) add_random_pair();
    wait_drained();
    hold_request = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_hits.size() != 0) begin
      $display("%0d expected results never arrived", expected_hits.size());
    end
    $display("Sent %0d circle-segment transactions: %0d hits, %0d misses checked.",
             pairs_sent, hits_seen, misses_seen);
    $display("Input was held back for %0d cycles; %0d failures in %0d cycles.",
             input_stall_cycles, failures, cycle_count);
    if (failures == 0 && expected_hits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/csc_pkg.sv
hdl/csc_front.sv
hdl/csc_queue.sv
hdl/csc_back.sv
hdl/circle_segment_collision_unit.sv
tb/circle_segment_collision_unit_tb.sv
